// ===== src/vet_pkg.sv =====
// Package with widths, codes and payload types of the vibrato extremum tracker.
package vet_pkg;

  localparam int TIME_BITS  = 20;
  localparam int PITCH_BITS = 18;
  localparam int GAP_BITS   = 10;
  localparam int CFG_BITS   = 20;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [PITCH_BITS-1:0] pitch_t;
  typedef logic [GAP_BITS-1:0]   gap_t;
  typedef logic [2:0]            action_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // List actions for the downstream maxima and minima lists.
  localparam action_t ACT_ADD_MAX          = 3'd0;
  localparam action_t ACT_REPL_MAX         = 3'd1;
  localparam action_t ACT_ADD_MIN          = 3'd2;
  localparam action_t ACT_REPL_MIN         = 3'd3;
  localparam action_t ACT_DROP_MIN_ADD_MAX = 3'd4;
  localparam action_t ACT_DROP_MAX_ADD_MIN = 3'd5;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ENABLE        = 2'd0;
  localparam cfg_idx_t REG_PITCH_DELTA   = 2'd1;
  localparam cfg_idx_t REG_MIN_GAP       = 2'd2;
  localparam cfg_idx_t REG_MAX_FIRST_GAP = 2'd3;

  // Configuration reset values.
  localparam pitch_t RST_PITCH_DELTA   = 18'd41;
  localparam gap_t   RST_MIN_GAP       = 10'd42;
  localparam time_t  RST_MAX_FIRST_GAP = 20'd500;

  // Extremum tracking mode, one-hot.
  typedef enum logic [4:0] {
    MODE_NONE      = 5'b00001,
    MODE_FIRST_MAX = 5'b00010,
    MODE_MAX       = 5'b00100,
    MODE_FIRST_MIN = 5'b01000,
    MODE_MIN       = 5'b10000
  } mode_t;

  typedef struct packed {
    logic   new_note;
    pitch_t pitch_sample;
  } in_item_t;

  typedef struct packed {
    action_t action;
    time_t   extremum_time;
    pitch_t  extremum_pitch;
  } out_item_t;

endpackage

// ===== src/vibrato_extremum_tracker_top.sv =====
// Vibrato extremum tracker: window classification, extremum filtering and result register.
// A result is in the output register in the cycle after its input transaction.
// Throughput: one input transaction per cycle while input ready is high; the classification and gap
// and pitch compares sit between the tracking state registers and the output register.
// Input ready stays high while the output register is empty or being drained.
// Synchronous active-low reset clears tracking state and loads configuration defaults.
module vibrato_extremum_tracker_top
  import vet_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  // Configuration registers.
  logic   enable_r;
  pitch_t pitch_delta_r;
  gap_t   min_gap_r;
  time_t  max_first_gap_r;

  // Tracking state.
  pitch_t      older_r, middle_r;
  logic [1:0]  held_r;
  time_t       step_r;
  mode_t       mode_r;
  time_t       last_t_r;
  pitch_t      last_p_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic in_accept;

  // Effective state after an optional new-note clear.
  pitch_t     older_e, middle_e, last_p_e, p;
  logic [1:0] held_e;
  time_t      step_e, last_t_e, t;
  mode_t      mode_e;

  // Classification and decision.
  logic    is_max, is_min;
  logic    emit;
  action_t act;
  mode_t   mode_set;
  pitch_t  dp;
  time_t   gap;
  logic    far_ok;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Apply the new-note clear before the sample is taken.
  always_comb begin
    p        = in_data.pitch_sample;
    older_e  = in_data.new_note ? '0 : older_r;
    middle_e = in_data.new_note ? '0 : middle_r;
    held_e   = in_data.new_note ? 2'd0 : held_r;
    step_e   = in_data.new_note ? '0 : step_r;
    mode_e   = in_data.new_note ? MODE_NONE : mode_r;
    last_t_e = in_data.new_note ? '0 : last_t_r;
    last_p_e = in_data.new_note ? '0 : last_p_r;
    t        = (step_e != '0) ? step_e - time_t'(1) : '0;
  end

  // Classify the window centre and compute the opposite-extremum tests.
  always_comb begin
    is_max = 1'b0;
    is_min = 1'b0;
    if (enable_r && held_e == 2'd2) begin
      if (older_e < middle_e && middle_e >= p) begin
        is_max = 1'b1;
      end else if (older_e > middle_e && middle_e <= p) begin
        is_min = 1'b1;
      end
    end
    dp     = (middle_e >= last_p_e) ? middle_e - last_p_e : last_p_e - middle_e;
    gap    = (t >= last_t_e) ? t - last_t_e : '0;
    far_ok = (dp >= pitch_delta_r) && (gap > time_t'(min_gap_r));
  end

  // Decide the list action from the mode and the kind found.
  always_comb begin
    emit     = 1'b0;
    act      = ACT_ADD_MAX;
    mode_set = mode_e;
    if (is_max) begin
      case (mode_e)
        MODE_FIRST_MAX, MODE_MAX: begin
          if (middle_e >= last_p_e) begin
            emit = 1'b1;
            act  = ACT_REPL_MAX;
          end
        end
        MODE_MIN: begin
          if (far_ok) begin
            emit     = 1'b1;
            act      = ACT_ADD_MAX;
            mode_set = MODE_MAX;
          end
        end
        MODE_FIRST_MIN: begin
          if (far_ok) begin
            emit = 1'b1;
            if (gap < max_first_gap_r) begin
              act      = ACT_ADD_MAX;
              mode_set = MODE_MAX;
            end else begin
              act      = ACT_DROP_MIN_ADD_MAX;
              mode_set = MODE_FIRST_MAX;
            end
          end
        end
        default: begin
          emit     = 1'b1;
          act      = ACT_ADD_MAX;
          mode_set = MODE_FIRST_MAX;
        end
      endcase
    end else if (is_min) begin
      case (mode_e)
        MODE_FIRST_MIN, MODE_MIN: begin
          if (middle_e <= last_p_e) begin
            emit = 1'b1;
            act  = ACT_REPL_MIN;
          end
        end
        MODE_MAX: begin
          if (far_ok) begin
            emit     = 1'b1;
            act      = ACT_ADD_MIN;
            mode_set = MODE_MIN;
          end
        end
        MODE_FIRST_MAX: begin
          if (far_ok) begin
            emit = 1'b1;
            if (gap < max_first_gap_r) begin
              act      = ACT_ADD_MIN;
              mode_set = MODE_MIN;
            end else begin
              act      = ACT_DROP_MAX_ADD_MIN;
              mode_set = MODE_FIRST_MIN;
            end
          end
        end
        default: begin
          emit     = 1'b1;
          act      = ACT_ADD_MIN;
          mode_set = MODE_FIRST_MIN;
        end
      endcase
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r        <= 1'b1;
      pitch_delta_r   <= RST_PITCH_DELTA;
      min_gap_r       <= RST_MIN_GAP;
      max_first_gap_r <= RST_MAX_FIRST_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:        enable_r        <= cfg_wdata[0];
        REG_PITCH_DELTA:   pitch_delta_r   <= cfg_wdata[PITCH_BITS-1:0];
        REG_MIN_GAP:       min_gap_r       <= cfg_wdata[GAP_BITS-1:0];
        REG_MAX_FIRST_GAP: max_first_gap_r <= cfg_wdata[TIME_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tracking state update on each input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      middle_r <= '0;
      held_r   <= 2'd0;
      step_r   <= '0;
      mode_r   <= MODE_NONE;
      last_t_r <= '0;
      last_p_r <= '0;
    end else if (in_accept) begin
      older_r  <= middle_e;
      middle_r <= p;
      held_r   <= (held_e < 2'd2) ? held_e + 2'd1 : held_e;
      step_r   <= (step_e != '1) ? step_e + time_t'(1) : step_e;
      if (emit) begin
        mode_r   <= mode_set;
        last_t_r <= t;
        last_p_r <= middle_e;
      end else begin
        mode_r   <= mode_e;
        last_t_r <= last_t_e;
        last_p_r <= last_p_e;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data_r.action         <= act;
      out_data_r.extremum_time  <= t;
      out_data_r.extremum_pitch <= middle_e;
    end
  end

  // A pending result always matches the recorded last extremum.
  a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_t_r == out_data_r.extremum_time &&
                     last_p_r == out_data_r.extremum_pitch))
    else $error("pending result differs from last extremum");

  // A disabled tracker produces no result.
  a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !enable_r) |=> !out_valid_r)
    else $error("result produced while disabled");

  // A new note restarts the step count.
  a_new_note_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.new_note) |=> (step_r == time_t'(1) && held_r == 2'd1))
    else $error("new note did not restart tracking");

  // Within a note the step count never decreases.
  a_step_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_data.new_note) |=> (step_r >= $past(step_r)))
    else $error("step counter went backwards");

endmodule
